// File: rtl/nested_cc_point_generator_core_assert.svh
// assertion helpers shared by the checker
`ifndef NESTED_CC_POINT_GENERATOR_CORE_ASSERT_SVH
`define NESTED_CC_POINT_GENERATOR_CORE_ASSERT_SVH

// checked only while out of reset
`define NCCPG_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked also during reset
`define NCCPG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/nccpg_pkg.sv
package nccpg_pkg;

    localparam int INDEX_W      = 12;
    localparam int COUNT_W      = 13;
    localparam int COUNT_RESET  = 4096;
    localparam int NUM_W        = 12;
    localparam int K_W          = 12;
    localparam int DEN_W        = 14;
    localparam int PHASE_W      = 32;
    localparam int DIVIDEND_W   = NUM_W + PHASE_W;
    localparam int DIV_SPS      = 4;
    localparam int DIV_STAGES   = DIVIDEND_W / DIV_SPS;
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_SPS   = 2;
    localparam int CORDIC_STAGES = CORDIC_STEPS / CORDIC_SPS;
    localparam int XY_W         = 34;
    localparam int Z_W          = 33;
    localparam int XY_FRAC      = 30;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef enum logic [2:0] {
        CODE_ZERO,
        CODE_NEG_ONE,
        CODE_POS_ONE,
        CODE_CORDIC,
        CODE_INVALID
    } t_code;

    typedef struct packed {
        t_code                     code;
        logic [INDEX_W-1:0]        index;
        logic [DIVIDEND_W-1:0]     dividend;
        logic [DEN_W-1:0]          den;
        logic [DEN_W-1:0]          rem;
        logic [PHASE_W-1:0]        phase;
        logic                      neg;
        logic signed [XY_W-1:0]    x;
        logic signed [XY_W-1:0]    y;
        logic signed [Z_W-1:0]     z;
    } t_pipe;

    function automatic logic [31:0] atan_turn(input int step);
        logic [31:0] v;
        case (step)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/nested_cc_point_generator_core.sv
// Nested Clenshaw-Curtis abscissa generator. Each beat on the input carries a point index
// and gives one beat on the output: the abscissa in signed Q1.FRAC_BITS and a flag for an
// index at or beyond the configured point count (value 0 then). One index is taken every
// clock while o_stall is low; each beat passes through a 44-bit restoring divider at four
// quotient bits per stage and a 30-step CORDIC at two steps per stage.
// Write point_count only while no beat is in flight.
module nested_cc_point_generator_core #(
    parameter int MAX_POINTS = 4096,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [nccpg_pkg::COUNT_W-1:0]       i_cfg_wr_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [nccpg_pkg::INDEX_W-1:0]       i_point_index,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [FRAC_BITS+1:0]         o_point_value,
    output logic                                o_index_invalid
);

    localparam int OUT_W   = FRAC_BITS + 2;
    localparam int PIPE_N  = 3 + nccpg_pkg::DIV_STAGES + nccpg_pkg::CORDIC_STAGES;
    localparam int FOLD_S  = 2 + nccpg_pkg::DIV_STAGES;
    localparam int CNT_W   = 17;
    localparam int SH      = nccpg_pkg::XY_FRAC - FRAC_BITS;
    localparam int HALF_SH = (SH > 0) ? SH - 1 : 0;
    localparam logic [CNT_W-1:0] MAXP = CNT_W'(MAX_POINTS);
    localparam logic signed [nccpg_pkg::XY_W-1:0] RND =
        (SH > 0) ? (nccpg_pkg::XY_W'(1) << HALF_SH) : '0;
    localparam logic signed [nccpg_pkg::XY_W-1:0] ONE = nccpg_pkg::XY_W'(1) << FRAC_BITS;

    logic [nccpg_pkg::COUNT_W-1:0] r_count;
    nccpg_pkg::t_pipe              r_pipe [0:PIPE_N-1];
    nccpg_pkg::t_pipe              n_pipe [0:PIPE_N-1];
    logic [PIPE_N:0]               r_vld;
    logic [PIPE_N:0]               adv;
    logic signed [OUT_W-1:0]       r_value;
    logic signed [OUT_W-1:0]       n_value;
    logic                          r_invalid;
    logic                          n_invalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= nccpg_pkg::COUNT_W'(nccpg_pkg::COUNT_RESET);
        end else if (i_cfg_wr_en) begin
            r_count <= i_cfg_wr_data;
        end
    end

    // ready ripples back through empty stages
    assign adv[PIPE_N] = !r_vld[PIPE_N] || !i_stall;
    for (genvar s = 0; s < PIPE_N; s++) begin : g_adv
        assign adv[s] = !r_vld[s] || adv[s+1];
    end
    assign o_stall = !adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int s = 1; s <= PIPE_N; s++) begin
                if (adv[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < PIPE_N; s++) begin
            if (adv[s]) begin
                r_pipe[s] <= n_pipe[s];
            end
        end
        if (adv[PIPE_N]) begin
            r_value   <= n_value;
            r_invalid <= n_invalid;
        end
    end

    // input capture
    always_comb begin
        n_pipe[0]       = '0;
        n_pipe[0].code  = nccpg_pkg::CODE_ZERO;
        n_pipe[0].index = i_point_index;
    end

    // level, position, divisor and numerator
    always_comb begin
        logic [nccpg_pkg::INDEX_W-1:0] p;
        logic [nccpg_pkg::INDEX_W-1:0] pm1;
        logic [nccpg_pkg::INDEX_W-1:0] d;
        logic [nccpg_pkg::INDEX_W-1:0] j;
        logic [nccpg_pkg::K_W-1:0]     k;
        logic [nccpg_pkg::NUM_W-1:0]   num;
        logic [CNT_W-1:0]              n_eff;
        logic [CNT_W-1:0]              kraw;
        p   = r_pipe[0].index;
        pm1 = p - nccpg_pkg::INDEX_W'(1);
        d   = '0;
        for (int b = 0; b < nccpg_pkg::INDEX_W; b++) begin
            if (pm1[b]) begin
                d = nccpg_pkg::INDEX_W'(1) << b;
            end
        end
        j     = p - d;
        n_eff = ({4'b0, r_count} > MAXP) ? MAXP : {4'b0, r_count};
        kraw  = n_eff - {5'b0, d} - CNT_W'(1);
        k     = (kraw > {5'b0, d}) ? d : kraw[nccpg_pkg::K_W-1:0];
        num   = j[0] ? (d + j) : (d + nccpg_pkg::NUM_W'(1) - j);
        n_pipe[1]          = '0;
        n_pipe[1].index    = p;
        n_pipe[1].den      = {k, 2'b00};
        n_pipe[1].dividend = {num, nccpg_pkg::PHASE_W'({k, 1'b0})};
        if ({5'b0, p} >= n_eff) begin
            n_pipe[1].code = nccpg_pkg::CODE_INVALID;
        end else if (p == nccpg_pkg::INDEX_W'(0)) begin
            n_pipe[1].code = nccpg_pkg::CODE_ZERO;
        end else if (p == nccpg_pkg::INDEX_W'(1)) begin
            n_pipe[1].code = nccpg_pkg::CODE_NEG_ONE;
        end else if (p == nccpg_pkg::INDEX_W'(2)) begin
            n_pipe[1].code = nccpg_pkg::CODE_POS_ONE;
        end else begin
            n_pipe[1].code = nccpg_pkg::CODE_CORDIC;
        end
    end

    for (genvar g = 0; g < nccpg_pkg::DIV_STAGES; g++) begin : g_div
        nccpg_div_stage #(
            .FIRST_STEP(g * nccpg_pkg::DIV_SPS)
        ) u_div (
            .i_st(r_pipe[1+g]),
            .o_st(n_pipe[2+g])
        );
    end

    // fold the phase into the right half plane
    always_comb begin
        logic [nccpg_pkg::PHASE_W-1:0] ph;
        logic [nccpg_pkg::PHASE_W-1:0] t;
        n_pipe[FOLD_S]     = r_pipe[FOLD_S-1];
        ph                 = r_pipe[FOLD_S-1].phase;
        t                  = ph + 32'h4000_0000;
        n_pipe[FOLD_S].neg = t[nccpg_pkg::PHASE_W-1];
        if (t[nccpg_pkg::PHASE_W-1]) begin
            ph = ph + 32'h8000_0000;
        end
        n_pipe[FOLD_S].z = signed'({ph[nccpg_pkg::PHASE_W-1], ph});
        n_pipe[FOLD_S].x = nccpg_pkg::CORDIC_GAIN;
        n_pipe[FOLD_S].y = '0;
    end

    for (genvar g = 0; g < nccpg_pkg::CORDIC_STAGES; g++) begin : g_cordic
        nccpg_cordic_stage #(
            .FIRST_STEP(g * nccpg_pkg::CORDIC_SPS)
        ) u_cordic (
            .i_st(r_pipe[FOLD_S+g]),
            .o_st(n_pipe[FOLD_S+1+g])
        );
    end

    // round, saturate, pick the result
    always_comb begin
        logic signed [nccpg_pkg::XY_W-1:0] r;
        r = (r_pipe[PIPE_N-1].x + RND) >>> SH;
        if (r > ONE) begin
            r = ONE;
        end
        if (r < -ONE) begin
            r = -ONE;
        end
        if (r_pipe[PIPE_N-1].neg) begin
            r = -r;
        end
        n_invalid = 1'b0;
        case (r_pipe[PIPE_N-1].code)
            nccpg_pkg::CODE_ZERO:    n_value = '0;
            nccpg_pkg::CODE_NEG_ONE: n_value = -ONE[OUT_W-1:0];
            nccpg_pkg::CODE_POS_ONE: n_value = ONE[OUT_W-1:0];
            nccpg_pkg::CODE_CORDIC:  n_value = r[OUT_W-1:0];
            nccpg_pkg::CODE_INVALID: begin
                n_value   = '0;
                n_invalid = 1'b1;
            end
            default: n_value = '0;
        endcase
    end

    assign o_valid         = r_vld[PIPE_N];
    assign o_point_value   = r_value;
    assign o_index_invalid = r_invalid;

endmodule

// File: rtl/nccpg_div_stage.sv
module nccpg_div_stage #(
    parameter int FIRST_STEP = 0
) (
    input  nccpg_pkg::t_pipe i_st,
    output nccpg_pkg::t_pipe o_st
);

    always_comb begin
        logic [nccpg_pkg::DEN_W:0]      t;
        logic [nccpg_pkg::DEN_W-1:0]    rem;
        logic [nccpg_pkg::PHASE_W-1:0]  phase;
        o_st  = i_st;
        rem   = i_st.rem;
        phase = i_st.phase;
        for (int s = 0; s < nccpg_pkg::DIV_SPS; s++) begin
            t = {rem, i_st.dividend[nccpg_pkg::DIVIDEND_W-1-FIRST_STEP-s]};
            if (t >= {1'b0, i_st.den}) begin
                t     = t - {1'b0, i_st.den};
                phase = {phase[nccpg_pkg::PHASE_W-2:0], 1'b1};
            end else begin
                phase = {phase[nccpg_pkg::PHASE_W-2:0], 1'b0};
            end
            rem = t[nccpg_pkg::DEN_W-1:0];
        end
        o_st.rem   = rem;
        o_st.phase = phase;
    end

endmodule

// File: rtl/nccpg_cordic_stage.sv
module nccpg_cordic_stage #(
    parameter int FIRST_STEP = 0
) (
    input  nccpg_pkg::t_pipe i_st,
    output nccpg_pkg::t_pipe o_st
);

    always_comb begin
        logic signed [nccpg_pkg::XY_W-1:0] x;
        logic signed [nccpg_pkg::XY_W-1:0] y;
        logic signed [nccpg_pkg::XY_W-1:0] xn;
        logic signed [nccpg_pkg::Z_W-1:0]  z;
        logic signed [nccpg_pkg::Z_W-1:0]  a;
        o_st = i_st;
        x = i_st.x;
        y = i_st.y;
        z = i_st.z;
        for (int s = 0; s < nccpg_pkg::CORDIC_SPS; s++) begin
            a = signed'({1'b0, nccpg_pkg::atan_turn(FIRST_STEP + s)});
            if (!z[nccpg_pkg::Z_W-1]) begin
                xn = x - (y >>> (FIRST_STEP + s));
                y  = y + (x >>> (FIRST_STEP + s));
                z  = z - a;
            end else begin
                xn = x + (y >>> (FIRST_STEP + s));
                y  = y - (x >>> (FIRST_STEP + s));
                z  = z + a;
            end
            x = xn;
        end
        o_st.x = x;
        o_st.y = y;
        o_st.z = z;
    end

endmodule

// File: rtl/nccpg_checker.sv
`include "nested_cc_point_generator_core_assert.svh"

module nccpg_checker #(
    parameter int FRAC_BITS = 16
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic signed [FRAC_BITS+1:0] o_point_value,
    input logic                        o_index_invalid
);

    localparam logic signed [FRAC_BITS+1:0] ONE = (FRAC_BITS+2)'(1) << FRAC_BITS;

    // a held input beat stays offered
    `NCCPG_ASSERT(a_in_hold, i_clk, i_rst_n, i_valid && o_stall |=> i_valid, "input beat dropped while stalled")

    // a held beat keeps its payload
    `NCCPG_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_point_value) && $stable(o_index_invalid), "output beat changed while stalled")

    // flagged beat carries zero
    `NCCPG_ASSERT(a_invalid_zero, i_clk, i_rst_n, o_valid && o_index_invalid |-> o_point_value == '0, "flagged beat with nonzero value")

    // abscissa stays in [-1, +1]
    `NCCPG_ASSERT(a_range, i_clk, i_rst_n, o_valid |-> o_point_value <= ONE && o_point_value >= -ONE, "abscissa out of range")

    // reset empties the pipeline
    `NCCPG_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "output valid right after reset")

endmodule

bind nested_cc_point_generator_core nccpg_checker #(
    .FRAC_BITS(FRAC_BITS)
) u_nccpg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_point_value  (o_point_value),
    .o_index_invalid(o_index_invalid)
);

// File: sim/nested_cc_point_generator_core_test.sv
module nested_cc_point_generator_core_test;

    localparam int MAX_PTS  = 4096;
    localparam int FRAC     = 16;
    localparam int OUT_W    = FRAC + 2;
    localparam int LATENCY  = 30;
    localparam int SETTLE   = LATENCY + 10;

    class point_scoreboard;
        int unsigned           point_count;
        logic [OUT_W-1:0]      value_q[$];
        logic                  invalid_q[$];
        int                    errors;
        int                    checked;
        int                    invalid_seen;

        function new();
            point_count  = nccpg_pkg::COUNT_RESET;
            errors       = 0;
            checked      = 0;
            invalid_seen = 0;
        endfunction

        function automatic longint cordic_cos(logic [31:0] phase);
            logic      neg;
            longint    x;
            longint    y;
            longint    z;
            longint    xn;
            longint    r;
            neg = 1'b0;
            x   = 652032874;
            y   = 0;
            if (((phase + 32'h40000000) & 32'h80000000) != 0) begin
                neg   = 1'b1;
                phase = phase + 32'h80000000;
            end
            z = longint'($signed(phase));
            for (int i = 0; i < nccpg_pkg::CORDIC_STEPS; i++) begin
                if (z >= 0) begin
                    xn = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - longint'(nccpg_pkg::atan_turn(i));
                end else begin
                    xn = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + longint'(nccpg_pkg::atan_turn(i));
                end
                x = xn;
            end
            r = (x + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC);
            if (r > (longint'(1) << FRAC))
                r = longint'(1) << FRAC;
            if (r < -(longint'(1) << FRAC))
                r = -(longint'(1) << FRAC);
            return neg ? -r : r;
        endfunction

        function void note_index(logic [nccpg_pkg::INDEX_W-1:0] idx);
            longint n;
            longint p;
            longint d;
            longint j;
            longint k;
            longint num;
            longint den;
            longint rem;
            longint phase;
            longint val;
            n = point_count;
            if (n > MAX_PTS)
                n = MAX_PTS;
            p = idx;
            if (p >= n) begin
                value_q.push_back('0);
                invalid_q.push_back(1'b1);
                return;
            end
            if (p == 0) begin
                val = 0;
            end else if (p == 1) begin
                val = -(longint'(1) << FRAC);
            end else if (p == 2) begin
                val = longint'(1) << FRAC;
            end else begin
                d = 2;
                while (2 * d + 1 <= p)
                    d = d * 2;
                j = p - d;
                k = n - d - 1;
                if (k > d)
                    k = d;
                num   = j[0] ? d + j : d + 1 - j;
                den   = 4 * k;
                rem   = num % den;
                phase = ((rem << 32) + 2 * k) / den;
                val   = cordic_cos(phase[31:0]);
            end
            value_q.push_back(val[OUT_W-1:0]);
            invalid_q.push_back(1'b0);
        endfunction

        function void check_result(logic [OUT_W-1:0] value, logic invalid);
            logic [OUT_W-1:0] exp_value;
            logic             exp_invalid;
            checked++;
            if (invalid)
                invalid_seen++;
            if (value_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat: value %0d invalid %0b",
                             $signed(value), invalid);
                return;
            end
            exp_value   = value_q.pop_front();
            exp_invalid = invalid_q.pop_front();
            if (value !== exp_value || invalid !== exp_invalid) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: value exp %0d got %0d, invalid exp %0b got %0b",
                             $signed(exp_value), $signed(value), exp_invalid, invalid);
            end
        endfunction

        function int pending();
            return value_q.size();
        endfunction
    endclass

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_cfg_wr_en;
    logic [nccpg_pkg::COUNT_W-1:0]       i_cfg_wr_data;
    logic                                i_valid;
    logic                                o_stall;
    logic [nccpg_pkg::INDEX_W-1:0]       i_point_index;
    logic                                o_valid;
    logic                                i_stall;
    logic signed [OUT_W-1:0]             o_point_value;
    logic                                o_index_invalid;

    point_scoreboard sb;
    int              sent;
    bit              hold_done;

    nested_cc_point_generator_core #(
        .MAX_POINTS(MAX_PTS),
        .FRAC_BITS (FRAC)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_point_index  (i_point_index),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_point_value  (o_point_value),
        .o_index_invalid(o_index_invalid)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic write_count(input logic [nccpg_pkg::COUNT_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.point_count = value;
    endtask

    task automatic send_index(input logic [nccpg_pkg::INDEX_W-1:0] idx, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_point_index <= idx;
        do
            @(posedge i_clk);
        while (o_stall);
        sb.note_index(idx);
        sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic random_phase(input logic [nccpg_pkg::COUNT_W-1:0] count, input int items);
        int                            n;
        logic [nccpg_pkg::INDEX_W-1:0] idx;
        write_count(count);
        n = (count > MAX_PTS) ? MAX_PTS : count;
        for (int i = 0; i < items; i++) begin
            if (n > 0 && $urandom_range(0, 9) < 8)
                idx = $urandom_range(0, n - 1);
            else
                idx = $urandom_range(0, 4095);
            send_index(idx, gap_len());
        end
        drain();
    endtask

    // receiver, with one long hold-off to back up the pipeline
    initial begin
        int stall_left;
        i_stall    = 1'b0;
        hold_done  = 1'b0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall)
                sb.check_result(o_point_value, o_index_invalid);
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (!hold_done && sent > 400) begin
                hold_done  = 1'b1;
                stall_left = 150;
                i_stall <= 1'b1;
            end else begin
                case ($urandom_range(0, 19))
                    0:       stall_left = $urandom_range(5, 25);
                    1, 2, 3: stall_left = $urandom_range(0, 2);
                    default: stall_left = 0;
                endcase
                i_stall <= (stall_left > 0);
            end
        end
    end

    initial begin
        #(12 * 400000);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        sb            = new();
        sent          = 0;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_valid       = 1'b0;
        i_point_index = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset count, level boundaries and the top index
        send_index(12'd0, 0);
        send_index(12'd1, 0);
        send_index(12'd2, 0);
        send_index(12'd3, 0);
        send_index(12'd4, 0);
        send_index(12'd5, 1);
        send_index(12'd8, 0);
        send_index(12'd9, 0);
        send_index(12'd2048, 0);
        send_index(12'd2049, 2);
        send_index(12'd4095, 0);
        drain();
        // empty rule
        write_count(13'd0);
        send_index(12'd0, 0);
        send_index(12'd4095, 0);
        drain();
        write_count(13'd1);
        send_index(12'd0, 0);
        send_index(12'd1, 0);
        drain();
        // count above the maximum, clipped
        write_count(13'h1FFF);
        send_index(12'd4095, 0);
        send_index(12'd3000, 0);
        drain();
        // truncated last level
        write_count(13'd6);
        send_index(12'd3, 0);
        send_index(12'd4, 0);
        send_index(12'd5, 0);
        send_index(12'd6, 0);
        drain();

        random_phase(13'd4096, 500);
        random_phase(13'h1FFF, 200);
        random_phase(13'd3, 60);
        random_phase(13'd17, 150);
        random_phase(13'd1000, 200);
        random_phase(13'd2, 40);
        random_phase(13'($urandom_range(1, 8191)), 150);
        random_phase(13'd2500, 150);

        $display("covered %0d index beats over counts 0 to 8191, %0d results checked",
                 sent, sb.checked);
        $display("%0d out-of-range indices flagged, long output hold-off applied",
                 sb.invalid_seen);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.pending());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/nccpg_pkg.sv
rtl/nccpg_div_stage.sv
rtl/nccpg_cordic_stage.sv
rtl/nested_cc_point_generator_core.sv
rtl/nccpg_checker.sv
sim/nested_cc_point_generator_core_test.sv
